FILE: sv/length_prefixed_block_deframer_assert.svh
// ----------------------------------------------------------------------------
// length prefixed block deframer assertion macros
// concurrent checks, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_BLOCK_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_BLOCK_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpbd check failed");
// next-cycle implication
`define LPBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpbd check failed");
`else
`define LPBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPBD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/lpbd_pkg.sv
// ----------------------------------------------------------------------------
// lpbd_pkg
// types and constants of the length prefixed block deframer
// ----------------------------------------------------------------------------
package lpbd_pkg;

	localparam int unsigned LEN_DIGITS_DEF = 10;
	localparam int unsigned CFG_W          = 16;
	localparam logic [15:0] CAP_RESET      = 16'd4096;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_CMD,
		PH_LEN,
		PH_KEEP,
		PH_SKIP,
		PH_END1,
		PH_END2
	} phase_t;

	typedef enum logic [1:0] {
		NS_WS,
		NS_DIGITS,
		NS_DONE
	} nstage_t;

	typedef enum logic [2:0] {
		K_DATA,
		K_OK,
		K_ENDERR,
		K_INCOMPLETE,
		K_MALFORMED
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		nstage_t     nstage;
		logic [31:0] length_value;
		logic [15:0] keep_rem;
		logic [31:0] skip_rem;
		logic [7:0]  command;
		logic [15:0] kept_length;
		logic        first_end_ok;
		logic        length_bad;
	} blk_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [7:0]  command;
		logic [15:0] length;
	} result_t;

	localparam blk_state_t STATE_RESET = '{
		phase:        PH_CMD,
		nstage:       NS_WS,
		length_value: 32'd0,
		keep_rem:     16'd0,
		skip_rem:     32'd0,
		command:      8'd0,
		kept_length:  16'd0,
		first_end_ok: 1'b0,
		length_bad:   1'b0
	};

endpackage

FILE: sv/lpbd_if.sv
// ----------------------------------------------------------------------------
// lpbd_if
// request channels of the deframer: raw stream in, results out
// ----------------------------------------------------------------------------
interface lpbd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] in_byte;

	modport source (output valid, output func, output in_byte, input ready);
	modport sink (input valid, input func, input in_byte, output ready);
endinterface

interface lpbd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_kind;
	logic [7:0]  out_byte;
	logic [7:0]  out_command;
	logic [15:0] out_length;

	modport source (output valid, output out_kind, output out_byte, output out_command,
		output out_length, input ready);
	modport sink (input valid, input out_kind, input out_byte, input out_command,
		input out_length, output ready);
endinterface

FILE: sv/length_prefixed_block_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_block_deframer
// splits a byte stream of command, ascii length, payload and cr lf blocks
// path: an accepted request is held in the input register, and its result in the result register
// throughput: one stream request per cycle while the result side does not stall, set by the single state update
// reset: arst_n clears parser state and output valid; buffer capacity returns to 4096
// ----------------------------------------------------------------------------
`include "length_prefixed_block_deframer_assert.svh"

module length_prefixed_block_deframer import lpbd_pkg::*; #(
	parameter int unsigned LEN_DIGITS = LEN_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [CFG_W-1:0] cfg_wdata,
	lpbd_in_if.sink          stream,
	lpbd_out_if.source       result
);

	localparam int unsigned DCW = $clog2(LEN_DIGITS + 1);

	logic           valid_s1;
	logic           func_s1;
	logic [7:0]     byte_s1;
	logic           adv;
	logic [15:0]    cap_q;
	blk_state_t     state_q;
	blk_state_t     state_nxt;
	logic [DCW-1:0] dc_q;
	logic [DCW-1:0] dc_nxt;
	logic           res_valid;
	result_t        res;
	logic           out_valid_q;
	result_t        out_q;

	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			func_s1 <= stream.func;
			byte_s1 <= stream.in_byte;
		end
	end

	lpbd_step #(
		.LEN_DIGITS (LEN_DIGITS),
		.DCW        (DCW)
	) u_step (
		.cur       (state_q),
		.dc_cur    (dc_q),
		.capacity  (cap_q),
		.func      (func_s1),
		.in_byte   (byte_s1),
		.nxt       (state_nxt),
		.dc_nxt    (dc_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			dc_q    <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
			dc_q    <= dc_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_kind    = out_q.kind;
	assign result.out_byte    = out_q.data;
	assign result.out_command = out_q.command;
	assign result.out_length  = out_q.length;

	`LPBD_ASSERT_IMP(a_keep_nonzero, clk, arst_n, state_q.phase == PH_KEEP, state_q.keep_rem != 16'd0)
	`LPBD_ASSERT_IMP(a_skip_nonzero, clk, arst_n, state_q.phase == PH_SKIP, state_q.skip_rem != 32'd0)
	`LPBD_ASSERT_NXT(a_result_held, clk, arst_n, adv && res_valid, out_valid_q)
	`LPBD_ASSERT_NXT(a_input_held, clk, arst_n, valid_s1 && !adv, valid_s1)

endmodule

FILE: sv/lpbd_step.sv
// ----------------------------------------------------------------------------
// lpbd_step
// next block state and optional result for one stream request
// ----------------------------------------------------------------------------
module lpbd_step import lpbd_pkg::*; #(
	parameter int unsigned LEN_DIGITS = LEN_DIGITS_DEF,
	parameter int unsigned DCW        = $clog2(LEN_DIGITS + 1)
) (
	input  blk_state_t        cur,
	input  logic [DCW-1:0]    dc_cur,
	input  logic [15:0]       capacity,
	input  logic              func,
	input  logic [7:0]        in_byte,
	output blk_state_t        nxt,
	output logic [DCW-1:0]    dc_nxt,
	output logic              res_valid,
	output result_t           res
);

	logic        is_space;
	logic        is_digit;
	logic [35:0] acc_wide;
	logic [31:0] acc_sat;
	logic [31:0] len;
	logic [15:0] keep;
	logic [31:0] skip;
	logic [DCW-1:0] dc_inc;
	logic [15:0] keep_dec;
	logic [31:0] skip_dec;

	assign is_space = (in_byte == CHAR_SPACE) || (in_byte >= CHAR_TAB && in_byte <= CHAR_CR);
	assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
	// value * 10 + digit
	assign acc_wide = ({4'd0, cur.length_value} << 3) + ({4'd0, cur.length_value} << 1)
		+ {28'd0, in_byte - CHAR_ZERO};
	assign acc_sat  = (acc_wide[35:32] != 4'd0) ? 32'hffff_ffff : acc_wide[31:0];
	assign dc_inc   = dc_cur + DCW'(1);
	assign keep_dec = cur.keep_rem - 16'd1;
	assign skip_dec = cur.skip_rem - 32'd1;

	always_comb begin
		nxt       = cur;
		dc_nxt    = dc_cur;
		res_valid = 1'b0;
		res       = '{kind: K_DATA, data: 8'd0, command: 8'd0, length: 16'd0};
		len       = 32'd0;
		keep      = 16'd0;
		skip      = 32'd0;
		if (func) begin
			if (cur.phase != PH_CMD) begin
				res_valid   = 1'b1;
				res.kind    = K_INCOMPLETE;
				res.command = cur.command;
				nxt         = STATE_RESET;
				nxt.command = cur.command;
				dc_nxt      = '0;
			end
		end else begin
			unique case (cur.phase)
				PH_CMD: begin
					nxt         = STATE_RESET;
					nxt.command = in_byte;
					nxt.phase   = PH_LEN;
					dc_nxt      = '0;
				end
				PH_LEN: begin
					case (cur.nstage)
						NS_WS: begin
							if (is_space) begin
								nxt.nstage = NS_WS;
							end else if (in_byte == CHAR_PLUS) begin
								nxt.nstage = NS_DIGITS;
							end else if (in_byte == CHAR_MINUS) begin
								nxt.length_bad = 1'b1;
								nxt.nstage     = NS_DIGITS;
							end else if (is_digit) begin
								nxt.length_value = acc_sat;
								nxt.nstage       = NS_DIGITS;
							end else begin
								nxt.nstage = NS_DONE;
							end
						end
						NS_DIGITS: begin
							if (is_digit) begin
								nxt.length_value = acc_sat;
							end else begin
								nxt.nstage = NS_DONE;
							end
						end
						default: begin
							nxt.nstage = cur.nstage;
						end
					endcase
					dc_nxt = dc_inc;
					if (dc_inc >= DCW'(LEN_DIGITS)) begin
						len  = nxt.length_bad ? 32'd0 : nxt.length_value;
						keep = (len < {16'd0, capacity}) ? len[15:0] : capacity;
						skip = len - {16'd0, keep};
						nxt.keep_rem    = keep;
						nxt.kept_length = keep;
						nxt.skip_rem    = skip;
						if (keep != 16'd0) begin
							nxt.phase = PH_KEEP;
						end else if (skip != 32'd0) begin
							nxt.phase = PH_SKIP;
						end else begin
							nxt.phase = PH_END1;
						end
					end
				end
				PH_KEEP: begin
					res_valid    = 1'b1;
					res.data     = in_byte;
					nxt.keep_rem = keep_dec;
					if (keep_dec == 16'd0) begin
						nxt.phase = (cur.skip_rem != 32'd0) ? PH_SKIP : PH_END1;
					end
				end
				PH_SKIP: begin
					nxt.skip_rem = skip_dec;
					if (skip_dec == 32'd0) begin
						nxt.phase = PH_END1;
					end
				end
				PH_END1: begin
					nxt.first_end_ok = (in_byte == CHAR_CR);
					nxt.phase        = PH_END2;
				end
				PH_END2: begin
					res_valid   = 1'b1;
					res.command = cur.command;
					if (cur.length_bad) begin
						res.kind = K_MALFORMED;
					end else begin
						res.kind   = (cur.first_end_ok && in_byte == CHAR_LF) ? K_OK : K_ENDERR;
						res.length = cur.kept_length;
					end
					nxt         = STATE_RESET;
					nxt.command = cur.command;
					dc_nxt      = '0;
				end
				default: begin
					nxt         = STATE_RESET;
					nxt.command = cur.command;
					dc_nxt      = '0;
				end
			endcase
		end
	end

endmodule

FILE: bench/tb_length_prefixed_block_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_block_deframer
// drives framed byte streams into the deframer and checks every result request
// against a cycle-free model of the parser, under several idling and capacity
// settings, including a long result stall and streams closed in mid-block
// ----------------------------------------------------------------------------
module tb_length_prefixed_block_deframer;
	import lpbd_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 6;
	localparam int unsigned LONG_STALL     = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic       func;
		logic [7:0] data;
	} stream_req_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wen;
	logic [CFG_W-1:0] cfg_wdata;

	lpbd_in_if  in_ch();
	lpbd_out_if out_ch();

	length_prefixed_block_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.stream    (in_ch.sink),
		.result    (out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	phase_t      pr_phase;
	nstage_t     pr_stage;
	int unsigned pr_digits;
	logic [31:0] pr_value;
	logic [31:0] pr_skip;
	logic [15:0] pr_keep;
	logic [15:0] pr_kept;
	logic [7:0]  pr_cmd;
	logic        pr_end_ok;
	logic        pr_neg;
	logic [15:0] capacity_now;

	stream_req_t stream_reqs_pending[$];
	result_t     results_due[$];
	int unsigned reqs_queued;
	int unsigned reqs_taken;
	int unsigned block_bytes;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int unsigned stall_asks;
	int unsigned stall_seen;
	int unsigned stall_left;
	bit          in_taken;
	bit          out_taken;

	function automatic void clear_block_state();
		pr_phase  = PH_CMD;
		pr_digits = 0;
		pr_stage  = NS_WS;
		pr_value  = '0;
		pr_keep   = '0;
		pr_skip   = '0;
		pr_kept   = '0;
		pr_end_ok = 1'b0;
		pr_neg    = 1'b0;
	endfunction

	function automatic void accumulate_digit(input logic [7:0] b);
		logic [35:0] v;
		v = 36'(pr_value) * 36'd10 + 36'(b - CHAR_ZERO);
		pr_value = (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic bit deframe_byte(input logic fn, input logic [7:0] b, output result_t r);
		logic [31:0] len;
		logic [15:0] keep;
		bit          gives;
		r = '0;
		gives = 1'b0;
		if (fn) begin
			if (pr_phase != PH_CMD) begin
				r.kind = K_INCOMPLETE;
				r.command = pr_cmd;
				gives = 1'b1;
				clear_block_state();
			end
		end else begin
			case (pr_phase)
				PH_CMD: begin
					clear_block_state();
					pr_cmd = b;
					pr_phase = PH_LEN;
				end
				PH_LEN: begin
					if (pr_stage == NS_WS) begin
						if (b == CHAR_PLUS) begin
							pr_stage = NS_DIGITS;
						end else if (b == CHAR_MINUS) begin
							pr_neg = 1'b1;
							pr_stage = NS_DIGITS;
						end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
							accumulate_digit(b);
							pr_stage = NS_DIGITS;
						end else if (!(b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) begin
							pr_stage = NS_DONE;
						end
					end else if (pr_stage == NS_DIGITS) begin
						if (b >= CHAR_ZERO && b <= CHAR_NINE)
							accumulate_digit(b);
						else
							pr_stage = NS_DONE;
					end
					pr_digits++;
					if (pr_digits >= LEN_DIGITS_DEF) begin
						len = pr_neg ? 32'd0 : pr_value;
						keep = (len < {16'd0, capacity_now}) ? len[15:0] : capacity_now;
						pr_keep = keep;
						pr_kept = keep;
						pr_skip = len - {16'd0, keep};
						if (pr_keep != 0)
							pr_phase = PH_KEEP;
						else if (pr_skip != 0)
							pr_phase = PH_SKIP;
						else
							pr_phase = PH_END1;
					end
				end
				PH_KEEP: begin
					r.kind = K_DATA;
					r.data = b;
					gives = 1'b1;
					pr_keep = pr_keep - 16'd1;
					if (pr_keep == 0)
						pr_phase = (pr_skip != 0) ? PH_SKIP : PH_END1;
				end
				PH_SKIP: begin
					pr_skip = pr_skip - 32'd1;
					if (pr_skip == 0)
						pr_phase = PH_END1;
				end
				PH_END1: begin
					pr_end_ok = (b == CHAR_CR);
					pr_phase = PH_END2;
				end
				PH_END2: begin
					gives = 1'b1;
					r.command = pr_cmd;
					if (pr_neg) begin
						r.kind = K_MALFORMED;
					end else begin
						r.kind = (pr_end_ok && b == CHAR_LF) ? K_OK : K_ENDERR;
						r.length = pr_kept;
					end
					clear_block_state();
				end
				default: begin
					clear_block_state();
				end
			endcase
		end
		return gives;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatches < 40)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	// stream driver
	always @(negedge clk) begin : stream_driver
		stream_req_t next_req;
		if (!in_ch.valid || in_taken) begin
			if (arst_n && stream_reqs_pending.size() != 0 &&
					$urandom_range(99) >= send_gap_pct) begin
				next_req = stream_reqs_pending.pop_front();
				in_ch.valid   <= 1'b1;
				in_ch.func    <= next_req.func;
				in_ch.in_byte <= next_req.data;
			end else begin
				in_ch.valid   <= 1'b0;
				in_ch.func    <= 1'($urandom_range(1));
				in_ch.in_byte <= 8'($urandom_range(255));
			end
		end
	end

	// result receiver, with the long hold-off counted here
	always @(negedge clk) begin
		if (stall_seen != stall_asks) begin
			stall_seen = stall_asks;
			stall_left = LONG_STALL;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t due;
		if (arst_n) begin
			in_taken = in_ch.valid && in_ch.ready;
			out_taken = out_ch.valid && out_ch.ready;
			if (in_taken) begin
				reqs_taken++;
				if (deframe_byte(in_ch.func, in_ch.in_byte, due))
					results_due.push_back(due);
			end
			if (out_taken) begin
				if (results_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d", out_ch.out_kind));
				end else begin
					due = results_due.pop_front();
					if (out_ch.out_kind !== 3'(due.kind))
						flag_mismatch($sformatf("kind %0d, want %0d", out_ch.out_kind, due.kind));
					if (out_ch.out_byte !== due.data)
						flag_mismatch($sformatf("byte %h, want %h", out_ch.out_byte, due.data));
					if (out_ch.out_command !== due.command)
						flag_mismatch($sformatf("command %h, want %h",
							out_ch.out_command, due.command));
					if (out_ch.out_length !== due.length)
						flag_mismatch($sformatf("length %0d, want %0d",
							out_ch.out_length, due.length));
				end
			end
			if (in_taken || out_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic queue_req(input logic fn, input logic [7:0] b);
		stream_req_t req;
		req.func = fn;
		req.data = b;
		stream_reqs_pending.push_back(req);
		reqs_queued++;
	endtask

	task automatic wait_until_drained();
		while (!(reqs_taken == reqs_queued && results_due.size() == 0))
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= cap;
		capacity_now = cap;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic queue_random_block();
		logic [7:0]  blk[$];
		logic [7:0]  b;
		int unsigned mode;
		int unsigned value;
		int unsigned ws;
		int unsigned n;
		bit          neg;
		bit          cut;
		mode = $urandom_range(99);
		neg = (mode >= 90);
		cut = 1'b0;
		// close while idle, ignored by the block
		if ($urandom_range(19) == 0)
			queue_req(1'b1, 8'($urandom_range(255)));
		blk.push_back(8'($urandom_range(255)));
		if (mode < 5) begin
			// saturating length, the payload never ends so the stream closes
			repeat (LEN_DIGITS_DEF) blk.push_back(CHAR_NINE);
			repeat ($urandom_range(5)) blk.push_back(8'($urandom_range(255)));
			cut = 1'b1;
		end else begin
			value = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
			repeat ($urandom_range(3)) begin
				ws = $urandom_range(5);
				blk.push_back((ws == 5) ? CHAR_SPACE : CHAR_TAB + 8'(ws));
			end
			if (neg)
				blk.push_back(CHAR_MINUS);
			else if ($urandom_range(3) == 0)
				blk.push_back(CHAR_PLUS);
			if (value != 0 || $urandom_range(3) != 0) begin
				repeat ($urandom_range(2)) blk.push_back(CHAR_ZERO);
				if (value >= 10)
					blk.push_back(CHAR_ZERO + 8'(value / 10));
				blk.push_back(CHAR_ZERO + 8'(value % 10));
			end
			if (blk.size() < 1 + LEN_DIGITS_DEF) begin
				do
					b = 8'($urandom_range(255));
				while (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_PLUS ||
					b == CHAR_MINUS || (b >= CHAR_ZERO && b <= CHAR_NINE));
				blk.push_back(b);
			end
			while (blk.size() < 1 + LEN_DIGITS_DEF)
				blk.push_back(8'($urandom_range(255)));
			if (!neg)
				repeat (value) blk.push_back(8'($urandom_range(255)));
			if ($urandom_range(6) == 0) begin
				blk.push_back($urandom_range(1) ? CHAR_CR : 8'($urandom_range(255)));
				blk.push_back($urandom_range(1) ? CHAR_LF : 8'($urandom_range(255)));
			end else begin
				blk.push_back(CHAR_CR);
				blk.push_back(CHAR_LF);
			end
			if ($urandom_range(11) == 0) begin
				n = $urandom_range(blk.size() - 1, 1);
				while (blk.size() > n)
					void'(blk.pop_back());
				cut = 1'b1;
			end
		end
		foreach (blk[i])
			queue_req(1'b0, blk[i]);
		if (cut)
			queue_req(1'b1, 8'($urandom_range(255)));
		block_bytes += blk.size();
	endtask

	task automatic run_phase(input logic [15:0] cap, input int unsigned gap_pct,
			input int unsigned stall_pct, input int unsigned bytes, input bit long_stall);
		int unsigned start;
		write_capacity(cap);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		start = block_bytes;
		while (block_bytes - start < bytes)
			queue_random_block();
		if (long_stall)
			stall_asks++;
		wait_until_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.in_byte = 8'h00;
		out_ch.ready = 1'b0;
		capacity_now = CAP_RESET;
		clear_block_state();
		pr_cmd = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// close while idle
		queue_req(1'b1, 8'h00);
		// minus sign, wrong end bytes: malformed whatever the end
		queue_req(1'b0, 8'hFF);
		queue_req(1'b0, CHAR_MINUS);
		queue_req(1'b0, CHAR_ZERO + 8'd5);
		queue_req(1'b0, 8'h00);
		repeat (LEN_DIGITS_DEF - 3) queue_req(1'b0, 8'hFF);
		queue_req(1'b0, 8'hFF);
		queue_req(1'b0, 8'h00);
		// every whitespace kind then a zero in the last digit slot
		queue_req(1'b0, 8'h00);
		for (int i = 0; i < LEN_DIGITS_DEF - 1; i++)
			queue_req(1'b0, (i < 5) ? CHAR_TAB + 8'(i) : CHAR_SPACE);
		queue_req(1'b0, CHAR_ZERO);
		queue_req(1'b0, CHAR_CR);
		queue_req(1'b0, CHAR_LF);
		// stream closed mid-length
		queue_req(1'b0, 8'h80);
		queue_req(1'b0, CHAR_PLUS);
		queue_req(1'b0, CHAR_ZERO + 8'd2);
		queue_req(1'b1, 8'hFF);
		wait_until_drained();

		run_phase(16'd8, 0, 0, 150, 1'b1);
		run_phase(16'd1, 49, 0, 140, 1'b0);
		run_phase(16'hFFFF, 0, 49, 140, 1'b0);
		run_phase(16'd0, 31, 31, 110, 1'b0);
		run_phase(16'd5, 31, 31, 140, 1'b0);

		if (results_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
